### rtl/itcm_pkg.sv
// ----------------------------------------------------------------------------
// itcm_pkg
// Shared types, constants and helpers for the image transform composer.
// ----------------------------------------------------------------------------
package itcm_pkg;

    localparam int MAX_SIDE   = 1024;
    localparam int WIDTH_W    = 11;
    localparam int CMD_W      = 4;
    localparam int AMOUNT_W   = 16;
    localparam int COORD_W    = 10;
    localparam int COLOR_W    = 24;
    localparam int ADDR_W     = 20;
    localparam int SHIFT_W    = 21;
    localparam int WIDE_W     = 23;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_SIDE);

    localparam logic signed [WIDE_W-1:0] SHIFT_MAX_W = 23'sd1048575;
    localparam logic signed [WIDE_W-1:0] SHIFT_MIN_W = -23'sd1048576;

    typedef enum logic [CMD_W-1:0] {
        CMD_UP         = 4'd0,
        CMD_LEFT       = 4'd1,
        CMD_DOWN       = 4'd2,
        CMD_RIGHT      = 4'd3,
        CMD_ROTATE_CW  = 4'd4,
        CMD_ROTATE_CCW = 4'd5,
        CMD_MIRROR_X   = 4'd6,
        CMD_MIRROR_Y   = 4'd7,
        CMD_MAP        = 4'd8,
        CMD_CLEAR      = 4'd9
    } cmd_t;

    typedef logic signed [SHIFT_W-1:0] shift_t;

    function automatic logic signed [WIDE_W-1:0] sext_shift(input shift_t v);
        sext_shift = $signed({{(WIDE_W-SHIFT_W){v[SHIFT_W-1]}}, v});
    endfunction

    function automatic shift_t sat_shift(input logic signed [WIDE_W-1:0] v);
        if (v > SHIFT_MAX_W)
        begin
            sat_shift = SHIFT_MAX_W[SHIFT_W-1:0];
        end
        else if (v < SHIFT_MIN_W)
        begin
            sat_shift = SHIFT_MIN_W[SHIFT_W-1:0];
        end
        else
        begin
            sat_shift = v[SHIFT_W-1:0];
        end
    endfunction

    function automatic shift_t neg_shift(input shift_t v);
        neg_shift = sat_shift(-sext_shift(v));
    endfunction

endpackage

### rtl/itcm_cmd_if.sv
// ----------------------------------------------------------------------------
// itcm_cmd_if
// Command channel: transform operations and pixels to map.
// ----------------------------------------------------------------------------
interface itcm_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [itcm_pkg::CMD_W-1:0]       command;
    logic [itcm_pkg::AMOUNT_W-1:0]    amount;
    logic [itcm_pkg::COORD_W-1:0]     pixel_row;
    logic [itcm_pkg::COORD_W-1:0]     pixel_col;
    logic [itcm_pkg::COLOR_W-1:0]     pixel_color;

    modport source (output valid, command, amount, pixel_row, pixel_col, pixel_color,
                    input ready);
    modport sink (input valid, command, amount, pixel_row, pixel_col, pixel_color,
                  output ready);
endinterface

### rtl/itcm_res_if.sv
// ----------------------------------------------------------------------------
// itcm_res_if
// Result channel: mapped pixel position, address, color and outside-image flag.
// ----------------------------------------------------------------------------
interface itcm_res_if;
    logic                             valid;
    logic                             ready;
    logic [itcm_pkg::COORD_W-1:0]     new_row;
    logic [itcm_pkg::COORD_W-1:0]     new_col;
    logic [itcm_pkg::ADDR_W-1:0]      frame_address;
    logic [itcm_pkg::COLOR_W-1:0]     color_out;
    logic                             outside_image;

    modport source (output valid, new_row, new_col, frame_address, color_out,
                    outside_image, input ready);
    modport sink (input valid, new_row, new_col, frame_address, color_out,
                  outside_image, output ready);
endinterface

### rtl/image_transform_compose_and_map.sv
// ----------------------------------------------------------------------------
// image_transform_compose_and_map
// Map transfers: the result is registered in the coordinate stage (s1) and then in
// the output stage; other commands update the transform registers on acceptance.
// Throughput: one command per cycle while the result channel accepts; set by the
// coordinate stage feeding the row*width multiply-add stage.
// Reset: identity transform, image width 1024, both stages empty.
// ----------------------------------------------------------------------------
module image_transform_compose_and_map (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [itcm_pkg::WIDTH_W-1:0]   cfg_wdata,
    itcm_cmd_if.sink                       cmd,
    itcm_res_if.source                     res
);

    localparam int RC_W = 13;

    logic [itcm_pkg::WIDTH_W-1:0] width_reg;
    itcm_pkg::shift_t             up_reg;
    itcm_pkg::shift_t             up_next;
    itcm_pkg::shift_t             left_reg;
    itcm_pkg::shift_t             left_next;
    logic [1:0]                   turns_reg;
    logic [1:0]                   turns_next;
    logic                         flip_rows_reg;
    logic                         flip_rows_next;
    logic                         flip_cols_reg;
    logic                         flip_cols_next;

    logic                         s1_valid_reg;
    logic [itcm_pkg::COORD_W-1:0] s1_row_reg;
    logic [itcm_pkg::COORD_W-1:0] s1_col_reg;
    logic                         s1_outside_reg;
    logic [itcm_pkg::COLOR_W-1:0] s1_color_reg;

    logic                         out_valid_reg;
    logic [itcm_pkg::COORD_W-1:0] out_row_reg;
    logic [itcm_pkg::COORD_W-1:0] out_col_reg;
    logic [itcm_pkg::ADDR_W-1:0]  out_addr_reg;
    logic [itcm_pkg::COLOR_W-1:0] out_color_reg;
    logic                         out_outside_reg;

    logic                         cmd_fire;
    logic                         map_fire;
    logic                         s1_advance;
    itcm_pkg::cmd_t               op;
    logic [1:0]                   rot_k;
    logic                         rot_en;

    logic [itcm_pkg::WIDTH_W-1:0] side;
    logic [itcm_pkg::WIDTH_W-1:0] last;
    logic signed [RC_W-1:0]       last_s;
    logic signed [RC_W-1:0]       row0;
    logic signed [RC_W-1:0]       col0;
    logic signed [RC_W-1:0]       row_rot;
    logic signed [RC_W-1:0]       col_rot;
    logic signed [RC_W-1:0]       row_flip;
    logic signed [RC_W-1:0]       col_flip;
    logic signed [itcm_pkg::WIDE_W-1:0] row_t;
    logic signed [itcm_pkg::WIDE_W-1:0] col_t;
    logic signed [itcm_pkg::WIDE_W-1:0] side_w;
    logic                         outside;
    logic [itcm_pkg::COORD_W+itcm_pkg::WIDTH_W-1:0] addr_full;

    assign op         = itcm_pkg::cmd_t'(cmd.command);
    assign s1_advance = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready  = !s1_valid_reg || s1_advance;
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign map_fire   = cmd_fire && (op == itcm_pkg::CMD_MAP);

    // effective side, clamped to 1..MAX_SIDE
    always_comb
    begin
        if (width_reg == '0)
        begin
            side = itcm_pkg::WIDTH_W'(1);
        end
        else if (width_reg > itcm_pkg::WIDTH_W'(itcm_pkg::MAX_SIDE))
        begin
            side = itcm_pkg::WIDTH_W'(itcm_pkg::MAX_SIDE);
        end
        else
        begin
            side = width_reg;
        end
    end

    assign last   = side - itcm_pkg::WIDTH_W'(1);
    assign last_s = $signed({2'b00, last});
    assign row0   = $signed({3'b000, cmd.pixel_row});
    assign col0   = $signed({3'b000, cmd.pixel_col});
    assign side_w = $signed({12'b0, side});

    // transform fold
    always_comb
    begin
        rot_en = 1'b0;
        rot_k  = cmd.amount[1:0];
        if (op == itcm_pkg::CMD_ROTATE_CCW)
        begin
            rot_k = 2'd0 - cmd.amount[1:0];
        end
        up_next        = up_reg;
        left_next      = left_reg;
        turns_next     = turns_reg;
        flip_rows_next = flip_rows_reg;
        flip_cols_next = flip_cols_reg;
        if (cmd_fire)
        begin
            case (op)
                itcm_pkg::CMD_UP:
                    up_next = itcm_pkg::sat_shift(itcm_pkg::sext_shift(up_reg)
                        + $signed({7'b0, cmd.amount}));
                itcm_pkg::CMD_LEFT:
                    left_next = itcm_pkg::sat_shift(itcm_pkg::sext_shift(left_reg)
                        + $signed({7'b0, cmd.amount}));
                itcm_pkg::CMD_DOWN:
                    up_next = itcm_pkg::sat_shift(itcm_pkg::sext_shift(up_reg)
                        - $signed({7'b0, cmd.amount}));
                itcm_pkg::CMD_RIGHT:
                    left_next = itcm_pkg::sat_shift(itcm_pkg::sext_shift(left_reg)
                        - $signed({7'b0, cmd.amount}));
                itcm_pkg::CMD_ROTATE_CW, itcm_pkg::CMD_ROTATE_CCW:
                    rot_en = 1'b1;
                itcm_pkg::CMD_MIRROR_X:
                begin
                    flip_rows_next = !flip_rows_reg;
                    up_next        = itcm_pkg::neg_shift(up_reg);
                end
                itcm_pkg::CMD_MIRROR_Y:
                begin
                    flip_cols_next = !flip_cols_reg;
                    left_next      = itcm_pkg::neg_shift(left_reg);
                end
                itcm_pkg::CMD_CLEAR:
                begin
                    up_next        = '0;
                    left_next      = '0;
                    turns_next     = '0;
                    flip_rows_next = 1'b0;
                    flip_cols_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        if (rot_en)
        begin
            case (rot_k)
                2'd1:
                begin
                    up_next        = left_reg;
                    left_next      = itcm_pkg::neg_shift(up_reg);
                    flip_rows_next = flip_cols_reg;
                    flip_cols_next = flip_rows_reg;
                    turns_next     = turns_reg + 2'd1;
                end
                2'd2:
                begin
                    up_next        = itcm_pkg::neg_shift(up_reg);
                    left_next      = itcm_pkg::neg_shift(left_reg);
                    flip_rows_next = !flip_rows_reg;
                    flip_cols_next = !flip_cols_reg;
                end
                2'd3:
                begin
                    up_next        = itcm_pkg::neg_shift(left_reg);
                    left_next      = up_reg;
                    flip_rows_next = flip_cols_reg;
                    flip_cols_next = flip_rows_reg;
                    turns_next     = turns_reg - 2'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // pixel coordinate mapping
    always_comb
    begin
        case (turns_reg)
            2'd1:
            begin
                row_rot = col0;
                col_rot = last_s - row0;
            end
            2'd2:
            begin
                row_rot = last_s - row0;
                col_rot = last_s - col0;
            end
            2'd3:
            begin
                row_rot = last_s - col0;
                col_rot = row0;
            end
            default:
            begin
                row_rot = row0;
                col_rot = col0;
            end
        endcase
        row_flip = flip_rows_reg ? (last_s - row_rot) : row_rot;
        col_flip = flip_cols_reg ? (last_s - col_rot) : col_rot;
        row_t = $signed({{(itcm_pkg::WIDE_W-RC_W){row_flip[RC_W-1]}}, row_flip})
              - itcm_pkg::sext_shift(up_reg);
        col_t = $signed({{(itcm_pkg::WIDE_W-RC_W){col_flip[RC_W-1]}}, col_flip})
              - itcm_pkg::sext_shift(left_reg);
        outside = (row_t < 0) || (row_t >= side_w) || (col_t < 0) || (col_t >= side_w);
    end

    assign addr_full = {11'b0, s1_row_reg} * {10'b0, side} + {11'b0, s1_col_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= itcm_pkg::WIDTH_RESET;
            up_reg        <= '0;
            left_reg      <= '0;
            turns_reg     <= '0;
            flip_rows_reg <= 1'b0;
            flip_cols_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_wdata;
            end
            up_reg        <= up_next;
            left_reg      <= left_next;
            turns_reg     <= turns_next;
            flip_rows_reg <= flip_rows_next;
            flip_cols_reg <= flip_cols_next;
            if (cmd.ready)
            begin
                s1_valid_reg <= map_fire;
            end
            if (!out_valid_reg || res.ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_fire)
        begin
            s1_row_reg     <= row_t[itcm_pkg::COORD_W-1:0];
            s1_col_reg     <= col_t[itcm_pkg::COORD_W-1:0];
            s1_outside_reg <= outside;
            s1_color_reg   <= cmd.pixel_color;
        end
        if (s1_advance)
        begin
            out_row_reg     <= s1_row_reg;
            out_col_reg     <= s1_col_reg;
            out_addr_reg    <= s1_outside_reg ? '0 : addr_full[itcm_pkg::ADDR_W-1:0];
            out_color_reg   <= s1_color_reg;
            out_outside_reg <= s1_outside_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.new_row       = out_row_reg;
    assign res.new_col       = out_col_reg;
    assign res.frame_address = out_addr_reg;
    assign res.color_out     = out_color_reg;
    assign res.outside_image = out_outside_reg;

endmodule
